>>> src/ldrs_pkg.sv
// Package for the LOOK disk request scheduler: sequencer states and field widths.
`default_nettype none

package ldrs_pkg;

  // Field widths of the stream payloads
  localparam int unsigned PosW  = 16;
  localparam int unsigned SeekW = 17;
  localparam int unsigned OutDataW = ((PosW + SeekW + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage : ldrs_pkg

`default_nettype wire

>>> src/look_disk_request_scheduler.sv
// LOOK disk request scheduler: request store, selection sequencer and result register.
//
// Operation: requests load one per cycle while the sequencer is in its load state;
// after the transaction marked last, each of the n results takes one scan of the store
// (one compare per cycle) plus an emit step, with one extra scan at the turnaround.
// Throughput: set by the single shared compare unit stepping through the store.
// Reset: asynchronous active low; clears sequencer, count, drop flag, start_head;
// the request store is not cleared and holds nothing valid until written.
`default_nettype none

module look_disk_request_scheduler #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration: start_head
  input  wire logic                         cfg_we_i,
  input  wire logic [ldrs_pkg::PosW-1:0]    cfg_wdata_i,
  // Request stream
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  wire logic [ldrs_pkg::PosW-1:0]    s_axis_tdata_i,  // [15:0] request_position
  input  wire logic                         s_axis_tlast_i,  // last_request
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [ldrs_pkg::OutDataW-1:0]     m_axis_tdata_o,  // [15:0] served_position,
                                                             // [32:16] seek_total, zero pad
  output logic                              m_axis_tlast_o,  // last_served
  output logic [0:0]                        m_axis_tuser_o   // [0] overflowed
);

  localparam int unsigned IdxW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned PosW = ldrs_pkg::PosW;
  localparam int unsigned SeekW = ldrs_pkg::SeekW;
  localparam int unsigned PadW = ldrs_pkg::OutDataW - PosW - SeekW;

  // Request store
  logic [PosW-1:0] mem_q [MAX_REQUESTS];

  ldrs_pkg::state_e state_q, state_d;

  logic [PosW-1:0]         head_q;
  logic [CntW-1:0]         count_q, count_d;
  logic                    drop_q, drop_d;
  logic [CntW-1:0]         scan_idx_q, scan_idx_d;
  logic [CntW-1:0]         emitted_q, emitted_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]         cmp_idx_q;
  logic [PosW-1:0]         rd_q;
  logic                    found_q, found_d;
  logic [PosW-1:0]         best_q, best_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;
  logic                    up_q, up_d;
  logic [MAX_REQUESTS-1:0] used_q, used_d;
  logic [PosW-1:0]         cur_q, cur_d;
  logic [SeekW-1:0]        seek_q, seek_d;
  logic                    out_vld_q, out_vld_d;
  logic [PosW-1:0]         out_pos_q;
  logic [SeekW-1:0]        out_seek_q;
  logic                    out_last_q;
  logic                    out_ovf_q;

  logic            in_fire;
  logic            issue;
  logic            scan_done;
  logic            emit_go;
  logic            batch_end;
  logic            in_range;
  logic            better;
  logic            cand_ok;
  logic [PosW-1:0] seek_step;
  logic [SeekW-1:0] seek_next;

  // Handshake and scan control
  assign s_axis_tready_o = (state_q == ldrs_pkg::ST_LOAD);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign issue     = (scan_idx_q < count_q);
  assign scan_done = (state_q == ldrs_pkg::ST_SCAN) && !issue && !cmp_vld_q;
  assign emit_go   = (state_q == ldrs_pkg::ST_EMIT) && (!out_vld_q || m_axis_tready_i);
  assign batch_end = ((emitted_q + CntW'(1)) == count_q);

  // Shared compare unit: qualify the entry read last cycle against head and best
  assign in_range = up_q ? (rd_q >= head_q) : (rd_q < head_q);
  assign better   = !found_q || (up_q ? (rd_q < best_q) : (rd_q > best_q));
  assign cand_ok  = cmp_vld_q && !used_q[cmp_idx_q] && in_range && better;

  // Head movement to the chosen request
  assign seek_step = (best_q >= cur_q) ? (best_q - cur_q) : (cur_q - best_q);
  assign seek_next = seek_q + SeekW'(seek_step);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ldrs_pkg::ST_LOAD: begin
        if (in_fire && s_axis_tlast_i) state_d = ldrs_pkg::ST_SCAN;
      end
      ldrs_pkg::ST_SCAN: begin
        if (scan_done && found_q) state_d = ldrs_pkg::ST_EMIT;
      end
      ldrs_pkg::ST_EMIT: begin
        if (emit_go) state_d = batch_end ? ldrs_pkg::ST_LOAD : ldrs_pkg::ST_SCAN;
      end
      default: state_d = ldrs_pkg::ST_LOAD;
    endcase
  end

  // Datapath and counters
  always_comb begin
    count_d    = count_q;
    drop_d     = drop_q;
    scan_idx_d = scan_idx_q;
    emitted_d  = emitted_q;
    cmp_vld_d  = 1'b0;
    found_d    = found_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    up_d       = up_q;
    used_d     = used_q;
    cur_d      = cur_q;
    seek_d     = seek_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    case (state_q)
      ldrs_pkg::ST_LOAD: begin
        if (in_fire) begin
          // store the request, or drop it when the store is full
          if (count_q < CntW'(MAX_REQUESTS)) count_d = count_q + CntW'(1);
          else drop_d = 1'b1;
          if (s_axis_tlast_i) begin
            scan_idx_d = '0;
            emitted_d  = '0;
            found_d    = 1'b0;
            up_d       = 1'b1;
            used_d     = '0;
            cur_d      = head_q;
            seek_d     = '0;
          end
        end
      end
      ldrs_pkg::ST_SCAN: begin
        // step through the store, one read a cycle
        if (issue) begin
          scan_idx_d = scan_idx_q + CntW'(1);
          cmp_vld_d  = 1'b1;
        end
        if (cand_ok) begin
          found_d    = 1'b1;
          best_d     = rd_q;
          best_idx_d = cmp_idx_q;
        end
        // nothing left above the head: reverse and rescan
        if (scan_done && !found_q) begin
          up_d       = 1'b0;
          scan_idx_d = '0;
        end
      end
      ldrs_pkg::ST_EMIT: begin
        if (emit_go) begin
          out_vld_d          = 1'b1;
          used_d[best_idx_q] = 1'b1;
          emitted_d          = emitted_q + CntW'(1);
          cur_d              = best_q;
          seek_d             = seek_next;
          scan_idx_d         = '0;
          found_d            = 1'b0;
          if (batch_end) begin
            count_d = '0;
            drop_d  = 1'b0;
          end
        end
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ldrs_pkg::ST_LOAD;
      head_q     <= '0;
      count_q    <= '0;
      drop_q     <= 1'b0;
      scan_idx_q <= '0;
      emitted_q  <= '0;
      cmp_vld_q  <= 1'b0;
      found_q    <= 1'b0;
      up_q       <= 1'b1;
      used_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) head_q <= cfg_wdata_i;
      count_q    <= count_d;
      drop_q     <= drop_d;
      scan_idx_q <= scan_idx_d;
      emitted_q  <= emitted_d;
      cmp_vld_q  <= cmp_vld_d;
      found_q    <= found_d;
      up_q       <= up_d;
      used_q     <= used_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    cur_q      <= cur_d;
    seek_q     <= seek_d;
    cmp_idx_q  <= scan_idx_q[IdxW-1:0];
    if (emit_go) begin
      out_pos_q  <= best_q;
      out_seek_q <= seek_next;
      out_last_q <= batch_end;
      out_ovf_q  <= drop_q;
    end
  end

  // Store: write on load, registered read during scan
  always_ff @(posedge clk_i) begin
    if (in_fire && (count_q < CntW'(MAX_REQUESTS))) begin
      mem_q[count_q[IdxW-1:0]] <= s_axis_tdata_i;
    end
    if ((state_q == ldrs_pkg::ST_SCAN) && issue) begin
      rd_q <= mem_q[scan_idx_q[IdxW-1:0]];
    end
  end

  // Result stream
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{PadW{1'b0}}, out_seek_q, out_pos_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

endmodule : look_disk_request_scheduler

`default_nettype wire

>>> bench/look_disk_request_scheduler_test.sv
// Self-checking bench for the LOOK disk request scheduler: stream stimulus against a sweep predictor.
`default_nettype none

module look_disk_request_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PosW         = ldrs_pkg::PosW;
  localparam int unsigned SeekW        = ldrs_pkg::SeekW;
  localparam int unsigned OutDataW     = ldrs_pkg::OutDataW;
  localparam int unsigned StoreDepth   = 32;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned EndCycles    = 100;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned RandomItems  = 85;
  localparam int unsigned HoldCycles   = 500;

  typedef struct packed {
    logic [PosW-1:0]  pos;
    logic [SeekW-1:0] seek;
    logic             is_last;
    logic             dropped;
  } visit_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_we      = 1'b0;
  logic [PosW-1:0]     cfg_wdata   = '0;
  logic                req_valid   = 1'b0;
  logic                req_ready;
  logic [PosW-1:0]     req_cyl     = '0;
  logic                req_last    = 1'b0;
  logic                visit_valid;
  logic                visit_ready = 1'b0;
  logic [OutDataW-1:0] visit_data;
  logic                visit_last;
  logic [0:0]          visit_user;

  // Predictor state: copy of the request store, batch flags and head register
  logic [PosW-1:0] pending_cyl [StoreDepth];
  int unsigned     pending_count = 0;
  logic            batch_dropped = 1'b0;
  logic [PosW-1:0] head_cyl      = '0;
  visit_t          expected_visits [$];

  int unsigned items_sent  = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  bit          no_idle     = 1'b0;

  look_disk_request_scheduler #(
    .MAX_REQUESTS(StoreDepth)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_cyl),
    .s_axis_tlast_i  (req_last),
    .m_axis_tvalid_o (visit_valid),
    .m_axis_tready_i (visit_ready),
    .m_axis_tdata_o  (visit_data),
    .m_axis_tlast_o  (visit_last),
    .m_axis_tuser_o  (visit_user)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive result back-pressure: long hold-off first, always ready under no_idle, else random idling
  always @(negedge clk) begin
    if (hold_left > 0) begin
      visit_ready <= 1'b0;
      hold_left--;
    end else if (no_idle) begin
      visit_ready <= 1'b1;
    end else begin
      visit_ready <= ($urandom_range(99) >= 16);
    end
  end

  // Record one accepted request; on the last one plan the whole LOOK sweep
  task automatic accept_request(input logic [PosW-1:0] cyl, input logic is_last);
    logic [PosW-1:0]  order [StoreDepth];
    logic [PosW-1:0]  key;
    logic [PosW-1:0]  cur;
    logic [SeekW-1:0] seek;
    int unsigned      n, split, i, j, k, idx;
    visit_t           v;
    if (pending_count < StoreDepth) begin
      pending_cyl[pending_count] = cyl;
      pending_count++;
    end else begin
      batch_dropped = 1'b1;
    end
    if (is_last) begin
      n = pending_count;
      // Sort the stored cylinders ascending
      for (i = 0; i < n; i++) begin
        key = pending_cyl[i];
        j = i;
        while (j > 0 && order[j-1] > key) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = key;
      end
      split = 0;
      while (split < n && order[split] < head_cyl) split++;
      // Sweep up from the head, then turn round and sweep down
      cur  = head_cyl;
      seek = '0;
      for (k = 0; k < n; k++) begin
        idx = (k < n - split) ? split + k : split - 1 - (k - (n - split));
        seek += (order[idx] > cur) ? order[idx] - cur : cur - order[idx];
        cur = order[idx];
        v.pos     = cur;
        v.seek    = seek;
        v.is_last = (k == n - 1);
        v.dropped = batch_dropped;
        expected_visits.push_back(v);
      end
      pending_count = 0;
      batch_dropped = 1'b0;
    end
  endtask

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [PosW-1:0] cyl, input logic is_last);
    while (!no_idle && $urandom_range(99) < 16) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_cyl   <= cyl;
    req_last  <= is_last;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    accept_request(cyl, is_last);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a batch of n requests; near_pct sets how many cluster round the head
  task automatic send_batch(input int unsigned n, input int unsigned near_pct);
    int unsigned     i, r;
    int              pick;
    logic [PosW-1:0] cyl;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < near_pct) begin
        pick = int'(head_cyl) + $urandom_range(16) - 8;
        if (pick < 0) pick = 0;
        if (pick > 65535) pick = 65535;
        cyl = PosW'(pick);
      end else if (r < near_pct + 10) begin
        cyl = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end else begin
        cyl = PosW'($urandom_range(65535));
      end
      send_request(cyl, i == n - 1);
    end
  endtask

  // Drop valid, wait for every expected visit, then let the block settle
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (expected_visits.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Write the head register while the block is idle
  task automatic set_head(input logic [PosW-1:0] cyl);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= cyl;
    head_cyl   = cyl;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Check each accepted visit against the oldest expectation
  always @(posedge clk) begin
    visit_t got, want;
    if (rst_n && visit_valid && visit_ready) begin
      got.pos     = visit_data[PosW-1:0];
      got.seek    = visit_data[PosW +: SeekW];
      got.is_last = visit_last;
      got.dropped = visit_user[0];
      if (expected_visits.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: unexpected visit pos=%h seek=%h last=%b ovf=%b", $realtime,
                   got.pos, got.seek, got.is_last, got.dropped);
      end else begin
        want = expected_visits.pop_front();
        if (got.pos !== want.pos || got.seek !== want.seek ||
            got.is_last !== want.is_last || got.dropped !== want.dropped) begin
          fail_count++;
          if (fail_count <= MaxReports) begin
            $write("%0t: visit mismatch exp pos=%h seek=%h last=%b ovf=%b,", $realtime,
                   want.pos, want.seek, want.is_last, want.dropped);
            $display(" got pos=%h seek=%h last=%b ovf=%b",
                     got.pos, got.seek, got.is_last, got.dropped);
          end
        end
      end
    end
  end

  // Hand-picked sweeps: extremes, equal-to-head, duplicates, one-sided batches
  task automatic test_directed_sweeps();
    // Head still at its reset value
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0000, 1'b0);
    send_request(16'h0000, 1'b1);
    set_head(16'h8000);
    send_request(16'h8000, 1'b0);
    send_request(16'h7FFF, 1'b0);
    send_request(16'hFFFF, 1'b0);
    send_request(16'h0001, 1'b0);
    send_request(16'h8001, 1'b0);
    send_request(16'h5555, 1'b0);
    send_request(16'hAAAA, 1'b1);
    set_head(16'hFFFF);
    send_request(16'h0000, 1'b0);
    send_request(16'h1234, 1'b1);
    send_request(16'hFFFF, 1'b1);
    // Largest seek: up to the top, then all the way down
    set_head(16'h0001);
    send_request(16'h0000, 1'b0);
    send_request(16'hFFFF, 1'b1);
    set_head(16'h0000);
    send_request(16'h0000, 1'b1);
    send_request(16'h0003, 1'b0);
    send_request(16'h0002, 1'b0);
    send_request(16'h0001, 1'b1);
    wait_for_drain();
  endtask

  // Fill the store exactly, overflow it (last request dropped too, its last mark still honoured), then recover
  task automatic test_store_full();
    set_head(16'h4000);
    send_batch(StoreDepth, 0);
    send_batch(StoreDepth + 3, 30);
    send_batch(3, 0);
    wait_for_drain();
  endtask

  // Run with no idling on either side
  task automatic test_back_to_back();
    set_head(PosW'($urandom_range(65535)));
    no_idle = 1'b1;
    send_batch(8, 30);
    send_batch(1, 0);
    send_batch(12, 80);
    wait_for_drain();
    no_idle = 1'b0;
  endtask

  // Hold off the result side long enough for the request side to stall
  task automatic test_output_stall();
    set_head(PosW'($urandom_range(65535)));
    hold_left = HoldCycles;
    send_batch(6, 30);
    send_batch(5, 0);
    send_batch(7, 80);
    wait_for_drain();
  endtask

  // Random batches: mostly small, a few full or overflowing, head moved often
  task automatic test_random_batches();
    int unsigned     first_item, n, r, near_pct;
    logic [PosW-1:0] cyl;
    first_item = items_sent;
    while (items_sent - first_item < RandomItems) begin
      if ($urandom_range(3) == 0) begin
        r = $urandom_range(9);
        if (r == 0) cyl = 16'h0000;
        else if (r == 1) cyl = 16'hFFFF;
        else cyl = PosW'($urandom_range(65535));
        set_head(cyl);
      end
      r = $urandom_range(99);
      if (r < 60) n = $urandom_range(6, 1);
      else if (r < 85) n = $urandom_range(20, 7);
      else if (r < 93) n = $urandom_range(StoreDepth, 21);
      else n = $urandom_range(StoreDepth + 6, StoreDepth + 1);
      r = $urandom_range(2);
      near_pct = (r == 0) ? 0 : (r == 1) ? 30 : 80;
      send_batch(n, near_pct);
    end
    wait_for_drain();
  endtask

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_sweeps();
    test_store_full();
    test_back_to_back();
    test_output_stall();
    test_random_batches();
    repeat (EndCycles) @(negedge clk);
    if (fail_count == 0 && expected_visits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : look_disk_request_scheduler_test

`default_nettype wire

>>> filelist.f
src/ldrs_pkg.sv
src/look_disk_request_scheduler.sv
bench/look_disk_request_scheduler_test.sv
